[hdl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared constants, round tables and control types for the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BLOCK_WDS  = 16;
   localparam int unsigned CHAIN_WDS  = 8;
   localparam int unsigned ROUNDS     = 64;
   localparam int unsigned WADDR_W    = $clog2(BLOCK_WDS);

   localparam logic [7:0] PAD_MARKER  = 8'h80;
   localparam logic [5:0] LEN_START   = 6'd56;
   localparam logic [5:0] FILL_LAST   = 6'd63;

   typedef logic [CHAIN_WDS-1:0][WORD_W-1:0] chain_type;

   localparam chain_type H_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic start;
      logic reinit;
   } core_ctrl_type;

   typedef struct packed {
      logic      busy;
      logic      done;
      chain_type chain;
   } core_stat_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

endpackage

`default_nettype wire

[hdl/sha_ifc.sv]
// ----------------------------------------------------------------------------
// SHA-256 engine channels
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, byte_value, byte_present, end_of_message, input ready);
   modport sink   (input valid, byte_value, byte_present, end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

[hdl/sha_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/sha_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds, one per cycle, reading block words from the buffer RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core
   import sha_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire core_ctrl_type       ctrl,
   output      core_stat_type       stat,
   output      logic [WADDR_W-1:0]  rd_addr,
   input  wire logic [WORD_W-1:0]   rd_data
);

   typedef enum logic [1:0] {IDLE, PRIME, ROUND, FINAL} state_type;

   state_type        state_ff;
   logic [5:0]       round_ff;
   chain_type        v_ff;
   chain_type        chain_ff;
   logic [WORD_W-1:0] win_ff [BLOCK_WDS];

   logic [WORD_W-1:0] w_in, sg0, sg1, t1, t2;

   always_comb begin
      sg0 = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      sg1 = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      if (round_ff < 6'(BLOCK_WDS)) begin
         w_in = rd_data;
      end else begin
         w_in = win_ff[0] + sg0 + win_ff[9] + sg1;
      end
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + K_TABLE[round_ff] + w_in;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      // The word for the next round is fetched in the cycle before it is used.
      rd_addr = (state_ff == ROUND) ? round_ff[WADDR_W-1:0] + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         round_ff <= '0;
         chain_ff <= H_INIT;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (ctrl.start) begin
                  v_ff     <= chain_ff;
                  round_ff <= '0;
                  state_ff <= PRIME;
               end else if (ctrl.reinit) begin
                  chain_ff <= H_INIT;
               end
            end
            PRIME: begin
               state_ff <= ROUND;
            end
            ROUND: begin
               v_ff <= {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
               for (int i = 0; i < BLOCK_WDS - 1; i++) begin
                  win_ff[i] <= win_ff[i+1];
               end
               win_ff[BLOCK_WDS-1] <= w_in;
               round_ff <= round_ff + 1'b1;
               if (round_ff == 6'(ROUNDS - 1)) begin
                  state_ff <= FINAL;
               end
            end
            FINAL: begin
               for (int i = 0; i < CHAIN_WDS; i++) begin
                  chain_ff[i] <= chain_ff[i] + v_ff[i];
               end
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign stat.busy  = (state_ff != IDLE);
   assign stat.done  = (state_ff == FINAL);
   assign stat.chain = chain_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == IDLE)
      else $error("compression started while busy");
   a_final_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == FINAL |-> $past(round_ff) == 6'(ROUNDS - 1))
      else $error("final step without last round");
   a_prime_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == PRIME |=> state_ff == ROUND && round_ff == '0)
      else $error("round zero not entered after prime");
`endif

endmodule

`default_nettype wire

[hdl/sha256_hash_engine.sv]
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Gathers message bytes into a word RAM, pads, compresses and emits digest.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req      in         byte_value, byte_present, end_of_message
//   rsp      out        digest_word, word_index, last_word
//
// A byte beat is taken whenever the block is idle; each 64th byte starts a
// compression (a prime step, 64 rounds, one chaining update). An end beat
// adds padding and one or two compressions, then four digest beats. Reset
// is synchronous; the block takes no beat while it compresses, pads or
// offers digest words, and a stalled rsp holds its word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine
   import sha_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sha_req_if.sink   req_ch,
   sha_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {IDLE, PAD, COMP, OUT} state_type;
   typedef enum logic [1:0] {PH_NONE, PH_MARK, PH_ZERO, PH_LEN} phase_type;

   state_type    state_ff;
   phase_type    phase_ff;
   logic [5:0]   fill_ff;
   logic [63:0]  total_ff;
   logic [63:0]  len_ff;
   logic [23:0]  word_ff;
   logic [1:0]   idx_ff;

   logic          put_en;
   logic [7:0]    put_byte;
   logic          accept;
   core_ctrl_type ctrl;
   core_stat_type stat;
   logic [WADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0]  rd_data;

   assign req_ch.ready = (state_ff == IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      put_en   = 1'b0;
      put_byte = req_ch.byte_value;
      if (state_ff == IDLE) begin
         put_en = accept && req_ch.byte_present;
      end else if (state_ff == PAD) begin
         case (phase_ff)
            PH_MARK: begin
               put_en   = 1'b1;
               put_byte = PAD_MARKER;
            end
            PH_ZERO: begin
               put_en   = (fill_ff != LEN_START);
               put_byte = '0;
            end
            PH_LEN: begin
               put_en   = 1'b1;
               put_byte = len_ff[63:56];
            end
            default: put_en = 1'b0;
         endcase
      end
   end

   assign ctrl.start  = put_en && (fill_ff == FILL_LAST);
   assign ctrl.reinit = (state_ff == OUT) && rsp_ch.ready && (idx_ff == 2'd3);

   sha_ram #(.WIDTH(WORD_W), .DEPTH(BLOCK_WDS)) u_block_ram (
      .clock   (clock),
      .wr_en   (put_en && (fill_ff[1:0] == 2'd3)),
      .wr_addr (fill_ff[5:2]),
      .wr_data ({word_ff, put_byte}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sha_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .stat    (stat),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         phase_ff <= PH_NONE;
         fill_ff  <= '0;
         total_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (put_en) begin
            word_ff <= {word_ff[15:0], put_byte};
            fill_ff <= fill_ff + 1'b1;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (req_ch.byte_present) begin
                     total_ff <= total_ff + 1'b1;
                  end
                  if (req_ch.end_of_message) begin
                     len_ff   <= {total_ff[60:0] + 61'(req_ch.byte_present), 3'b000};
                     phase_ff <= PH_MARK;
                     state_ff <= ctrl.start ? COMP : PAD;
                  end else if (ctrl.start) begin
                     state_ff <= COMP;
                  end
               end
            end
            PAD: begin
               case (phase_ff)
                  PH_MARK: phase_ff <= PH_ZERO;
                  PH_ZERO: begin
                     if (fill_ff == LEN_START) begin
                        phase_ff <= PH_LEN;
                     end
                  end
                  PH_LEN:  len_ff <= {len_ff[55:0], 8'h00};
                  default: phase_ff <= PH_NONE;
               endcase
               if (ctrl.start) begin
                  state_ff <= COMP;
               end
            end
            COMP: begin
               if (stat.done) begin
                  if (phase_ff == PH_LEN) begin
                     idx_ff   <= '0;
                     state_ff <= OUT;
                  end else if (phase_ff == PH_NONE) begin
                     state_ff <= IDLE;
                  end else begin
                     state_ff <= PAD;
                  end
               end
            end
            OUT: begin
               if (rsp_ch.ready) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == 2'd3) begin
                     total_ff <= '0;
                     fill_ff  <= '0;
                     phase_ff <= PH_NONE;
                     state_ff <= IDLE;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = (state_ff == OUT);
   assign rsp_ch.digest_word = {stat.chain[{idx_ff, 1'b0}], stat.chain[{idx_ff, 1'b1}]};
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last_word   = (idx_ff == 2'd3);

`ifndef NO_ASSERTIONS
   a_no_input_while_busy: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_ch.ready)
      else $error("input taken during compression");
   a_out_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready && !stat.busy)
      else $error("digest offered while block active");
   a_restart_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word |=> fill_ff == '0 && total_ff == '0)
      else $error("state not cleared after digest");
   a_out_after_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> fill_ff == '0)
      else $error("digest before block boundary");
`endif

endmodule

`default_nettype wire
